// File: rtl/core/assert_macros.svh
// Assertion macros shared by the postfix evaluator RTL.
// Needs signals clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define RPN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RPN_ASSERT_NEVER(lbl, cond, msg) \
  `RPN_ASSERT(lbl, !(cond), msg)
`else
`define RPN_ASSERT(lbl, prop, msg)
`define RPN_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// File: rtl/core/rpn_pkg.sv
// Types and constants of the postfix expression evaluator.
// Used by rpn_stack, rpn_alu and rpn_stack_evaluator; no dependencies.
package rpn_pkg;

  localparam int DATA_W      = 32;
  localparam int MODE_W      = 4;
  localparam int ERR_W       = 2;
  localparam int STACK_DEPTH = 64;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(DATA_W);
  localparam int IN_TDATA_W  = ((MODE_W + DATA_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DATA_W + ERR_W + 7) / 8) * 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH = 4'd0,
    MODE_GE   = 4'd1,
    MODE_LE   = 4'd2,
    MODE_EQ   = 4'd3,
    MODE_LT   = 4'd4,
    MODE_GT   = 4'd5,
    MODE_MUL  = 4'd6,
    MODE_DIV  = 4'd7,
    MODE_ADD  = 4'd8,
    MODE_SUB  = 4'd9
  } mode_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_UNDER = 2'd1,
    ERR_OVER  = 2'd2,
    ERR_DIV0  = 2'd3
  } err_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_req_t;

  typedef struct packed {
    logic over;
    logic under;
  } stk_flags_t;

  typedef struct packed {
    logic  start;
    mode_t op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic div0;
  } alu_rsp_t;

endpackage

// File: rtl/core/rpn_stack.sv
// Operand stack: pointer, overflow/underflow checks and the stack memory.
// Depends on rpn_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rpn_stack import rpn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  stk_req_t          req,
  input  logic [DATA_W-1:0] wr_data,
  output logic [DATA_W-1:0] rd_data,
  output stk_flags_t        flags
);

  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
  logic [SP_W-1:0]   sp_r, sp_nxt;
  logic [SP_W-1:0]   sp_dec;
  logic [DATA_W-1:0] rd_q_r;
  logic              rd_ok_r;
  logic              push_ok, pop_ok;

  assign push_ok = req.push && (sp_r < SP_W'(STACK_DEPTH));
  assign pop_ok  = req.pop && (sp_r != '0);
  assign sp_dec  = sp_r - SP_W'(1);

  assign flags.over  = req.push && !push_ok;
  assign flags.under = req.pop && !pop_ok;

  always_comb begin
    sp_nxt = sp_r;
    if (push_ok) begin
      sp_nxt = sp_r + SP_W'(1);
    end else if (pop_ok) begin
      sp_nxt = sp_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      stack_mem[sp_r[ADDR_W-1:0]] <= wr_data;
    end
    if (pop_ok) begin
      rd_q_r <= stack_mem[sp_dec[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r    <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      sp_r <= sp_nxt;
      if (req.pop) begin
        rd_ok_r <= pop_ok;
      end
    end
  end

  // an empty-stack pop reads as zero
  assign rd_data = rd_ok_r ? rd_q_r : '0;

  `RPN_ASSERT(a_sp_range, sp_r <= SP_W'(STACK_DEPTH), "stack pointer beyond depth")
  `RPN_ASSERT_NEVER(a_push_pop, req.push && req.pop, "push and pop in one cycle")

endmodule

// File: rtl/core/rpn_alu.sv
// Shared arithmetic unit: compares, add, sub and multiply computed combinationally and registered on start,
// signed divide by 32 one-bit restoring steps. Depends on rpn_pkg.
`include "assert_macros.svh"
module rpn_alu import rpn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  alu_req_t          req,
  input  logic [DATA_W-1:0] lhs,
  input  logic [DATA_W-1:0] rhs,
  output alu_rsp_t          rsp,
  output logic [DATA_W-1:0] result
);

  logic              busy_r, fix_r, done_r, div0_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DATA_W-1:0] rem_r, quo_r, dvs_r, result_r;
  logic              neg_r;
  logic [DATA_W-1:0] quick_res, prod, abs_l, abs_r;
  logic              lhs_lt_rhs, rhs_lt_lhs;
  logic [DATA_W:0]   shifted;
  logic [DATA_W+1:0] diff;

  assign lhs_lt_rhs = $signed(lhs) < $signed(rhs);
  assign rhs_lt_lhs = $signed(rhs) < $signed(lhs);
  assign prod       = lhs * rhs;
  assign abs_l      = lhs[DATA_W-1] ? (~lhs + DATA_W'(1)) : lhs;
  assign abs_r      = rhs[DATA_W-1] ? (~rhs + DATA_W'(1)) : rhs;

  always_comb begin
    case (req.op)
      MODE_GE:  quick_res = {{(DATA_W-1){1'b0}}, !lhs_lt_rhs};
      MODE_LE:  quick_res = {{(DATA_W-1){1'b0}}, !rhs_lt_lhs};
      MODE_EQ:  quick_res = {{(DATA_W-1){1'b0}}, lhs == rhs};
      MODE_LT:  quick_res = {{(DATA_W-1){1'b0}}, lhs_lt_rhs};
      MODE_GT:  quick_res = {{(DATA_W-1){1'b0}}, rhs_lt_lhs};
      MODE_MUL: quick_res = prod;
      MODE_ADD: quick_res = lhs + rhs;
      MODE_SUB: quick_res = lhs - rhs;
      default:  quick_res = '0;
    endcase
  end

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign shifted = {rem_r, quo_r[DATA_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
      div0_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      div0_r <= 1'b0;
      if (req.start) begin
        if (req.op == MODE_DIV && rhs != '0) begin
          busy_r <= 1'b1;
        end else begin
          done_r <= 1'b1;
          div0_r <= (req.op == MODE_DIV);
        end
      end else if (busy_r && cnt_r == CNT_W'(DATA_W - 1)) begin
        busy_r <= 1'b0;
        fix_r  <= 1'b1;
      end else if (fix_r) begin
        fix_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt_r    <= '0;
      rem_r    <= '0;
      quo_r    <= abs_l;
      dvs_r    <= abs_r;
      neg_r    <= lhs[DATA_W-1] ^ rhs[DATA_W-1];
      result_r <= quick_res;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (!diff[DATA_W+1]) begin
        rem_r <= diff[DATA_W-1:0];
        quo_r <= {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[DATA_W-1:0];
        quo_r <= {quo_r[DATA_W-2:0], 1'b0};
      end
    end else if (fix_r) begin
      result_r <= neg_r ? (~quo_r + DATA_W'(1)) : quo_r;
    end
  end

  assign rsp.done = done_r;
  assign rsp.div0 = div0_r;
  assign result   = result_r;

  `RPN_ASSERT_NEVER(a_start_busy, req.start && (busy_r || fix_r), "start while dividing")

endmodule

// File: rtl/core/rpn_stack_evaluator.sv
// Postfix expression evaluator top level: token sequencer, sticky error
// and result register. Depends on rpn_pkg, rpn_stack, rpn_alu.
//
//   port group | dir | contents
//   in_*       | in  | tdata: mode[3:0], operand_value[35:4]; tlast: end of expression
//   out_*      | out | tdata: expression_value[31:0], error_code[33:32]
//
// A push or no-op token needs only ST_IDLE; an operator passes ST_POPR, ST_POPL, ST_LOAD
// and ST_EXEC, where divide waits while the shared unit runs 32 one-bit restoring steps
// plus a sign fix; a last token adds ST_POPT (pop the top) and ST_EMIT (load the result).
// Tokens are taken while a result waits; a second result holds until it drains.
// Reset (rst_n low, synchronous) empties the stack and clears the error.
`include "assert_macros.svh"
module rpn_stack_evaluator import rpn_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // mode[3:0], operand_value[35:4]
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // expression_value[31:0], error_code[33:32]
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b000_0001,
    ST_POPR = 7'b000_0010,
    ST_POPL = 7'b000_0100,
    ST_LOAD = 7'b000_1000,
    ST_EXEC = 7'b001_0000,
    ST_POPT = 7'b010_0000,
    ST_EMIT = 7'b100_0000
  } state_t;

  state_t            state_r, state_nxt;
  mode_t             mode_r, in_mode;
  logic              last_r;
  logic [DATA_W-1:0] rhs_r;
  err_t              sticky_r, sticky_nxt;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_value_r;
  err_t              out_err_r;
  logic              in_fire, is_op, out_load;

  stk_req_t          stk_req;
  stk_flags_t        stk_flags;
  logic [DATA_W-1:0] stk_wdata, stk_rdata;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  logic [DATA_W-1:0] alu_result;

  rpn_stack u_stack (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (stk_req),
    .wr_data (stk_wdata),
    .rd_data (stk_rdata),
    .flags   (stk_flags)
  );

  rpn_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .lhs    (stk_rdata),
    .rhs    (rhs_r),
    .rsp    (alu_rsp),
    .result (alu_result)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_mode   = mode_t'(in_tdata[MODE_W-1:0]);
  assign out_load  = (state_r == ST_EMIT) && (!out_valid_r || out_tready);

  always_comb begin
    case (in_mode)
      MODE_GE, MODE_LE, MODE_EQ, MODE_LT, MODE_GT,
      MODE_MUL, MODE_DIV, MODE_ADD, MODE_SUB: is_op = 1'b1;
      default:                                is_op = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    stk_req.push  = 1'b0;
    stk_req.pop   = 1'b0;
    stk_wdata     = in_tdata[MODE_W +: DATA_W];
    alu_req.start = 1'b0;
    alu_req.op    = mode_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (is_op) begin
            state_nxt = ST_POPR;
          end else begin
            stk_req.push = (in_mode == MODE_PUSH);
            state_nxt    = in_tlast ? ST_POPT : ST_IDLE;
          end
        end
      end
      ST_POPR: begin
        stk_req.pop = 1'b1;
        state_nxt   = ST_POPL;
      end
      ST_POPL: begin
        stk_req.pop = 1'b1;
        state_nxt   = ST_LOAD;
      end
      ST_LOAD: begin
        alu_req.start = 1'b1;
        state_nxt     = ST_EXEC;
      end
      ST_EXEC: begin
        if (alu_rsp.done) begin
          stk_req.push = 1'b1;
          stk_wdata    = alu_result;
          state_nxt    = last_r ? ST_POPT : ST_IDLE;
        end
      end
      ST_POPT: begin
        stk_req.pop = 1'b1;
        state_nxt   = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // keep only the first error; divide by zero comes before the push of its result
  always_comb begin
    sticky_nxt = sticky_r;
    if (out_load) begin
      sticky_nxt = ERR_NONE;
    end else if (sticky_r == ERR_NONE) begin
      if (alu_rsp.done && alu_rsp.div0) begin
        sticky_nxt = ERR_DIV0;
      end else if (stk_flags.over) begin
        sticky_nxt = ERR_OVER;
      end else if (stk_flags.under) begin
        sticky_nxt = ERR_UNDER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sticky_r    <= ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      sticky_r <= sticky_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r <= in_mode;
      last_r <= in_tlast;
    end
    if (state_r == ST_POPL) begin
      rhs_r <= stk_rdata;
    end
    if (out_load) begin
      out_value_r <= stk_rdata;
      out_err_r   <= sticky_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - DATA_W - ERR_W){1'b0}}, out_err_r, out_value_r};

  `RPN_ASSERT(a_done_in_exec, alu_rsp.done |-> state_r == ST_EXEC, "unit done outside exec")
  `RPN_ASSERT(a_sticky_clear, out_load |=> sticky_r == ERR_NONE, "error not cleared on result")

endmodule
